/* sv/tcd_pkg.sv */
// tcd_pkg: shared types and constants for the touch channel debouncer.
// Used by tcd_lane and touch_channel_debouncer_top; no dependencies.
`default_nettype none

package tcd_pkg;

   localparam int RAW_W            = 12;   // raw bitmap and event mask width
   localparam int TIME_W           = 32;   // millisecond time width
   localparam int SETTLE_W         = 16;   // settle register width
   localparam int CHANNELS_DEFAULT = 12;

   localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd200;

   // byte-padded beat widths
   localparam int REQ_DATA_W = ((RAW_W + TIME_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((3 * RAW_W + 7) / 8) * 8;

   typedef enum logic [1:0] {
      PH_IDLE           = 2'd0,
      PH_TOUCH_SETTLE   = 2'd1,
      PH_TOUCHED        = 2'd2,
      PH_RELEASE_SETTLE = 2'd3
   } phase_type;

   // per-lane status toward the top level
   typedef struct packed {
      logic touch_ev;
      logic rel_ev;
      logic stable;
   } lane_out_type;

endpackage

`default_nettype wire

/* sv/tcd_lane.sv */
// tcd_lane: four-phase debouncer for one electrode, with its settle timer mark.
// Depends on tcd_pkg.
`default_nettype none

module tcd_lane (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,     // poll is consumed this cycle
   input  wire logic                        level,
   input  wire logic [tcd_pkg::TIME_W-1:0]  now,
   input  wire logic [tcd_pkg::SETTLE_W-1:0] settle,
   output tcd_pkg::lane_out_type            lane_out
);
   import tcd_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [TIME_W-1:0]   mark_ff, mark_in;
   logic [TIME_W-1:0]   elapsed;
   logic                settled;
   logic                touch_ev, rel_ev;

   // wrapping difference, unsigned compare
   assign elapsed = now - mark_ff;
   assign settled = elapsed >= {{(TIME_W - SETTLE_W){1'b0}}, settle};

   always_comb begin
      phase_in = phase_ff;
      mark_in  = mark_ff;
      touch_ev = 1'b0;
      rel_ev   = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (level) begin
               mark_in  = now;
               phase_in = PH_TOUCH_SETTLE;
            end
         end
         PH_TOUCH_SETTLE: begin
            if (!level) begin
               phase_in = PH_IDLE;
            end else if (settled) begin
               phase_in = PH_TOUCHED;
               touch_ev = 1'b1;
            end
         end
         PH_TOUCHED: begin
            if (!level) begin
               mark_in  = now;
               phase_in = PH_RELEASE_SETTLE;
            end
         end
         PH_RELEASE_SETTLE: begin
            if (level) begin
               phase_in = PH_TOUCHED;
            end else if (settled) begin
               phase_in = PH_IDLE;
               rel_ev   = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   assign lane_out.touch_ev = touch_ev;
   assign lane_out.rel_ev   = rel_ev;
   assign lane_out.stable   = (phase_in == PH_TOUCHED) || (phase_in == PH_RELEASE_SETTLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (step) begin
         phase_ff <= phase_in;
      end
   end

   // mark is only read in a settling phase, always written on entry
   always_ff @(posedge clock) begin
      if (step) begin
         mark_ff <= mark_in;
      end
   end

endmodule

`default_nettype wire

/* sv/touch_channel_debouncer_top.sv */
// touch_channel_debouncer_top: per-electrode touch/release debouncer, poll in, masks out.
// Depends on tcd_pkg and tcd_lane.
//
//   channel | dir | handshake            | beat contents
//   --------+-----+----------------------+-------------------------------------------
//   req     | in  | req_tvalid/tready    | one poll: raw_touch, now_ms
//   rsp     | out | rsp_tvalid/tready    | one result: touch, release, stable masks
//   csr     | in  | csr_valid/csr_ready  | settle_ms write, always ready
//
// One poll per cycle sustained while rsp is taken. A poll passes an input register,
// then the lane update (one 32-bit subtract and compare per lane) that loads the result
// register and the lane phase state in the same edge.
// Reset clears all phases to idle, empties both stages and sets settle_ms to 200.
// A stalled rsp holds its beat; req stays ready as long as the input stage can drain.
`default_nettype none

module touch_channel_debouncer_top #(
   parameter int CHANNELS = tcd_pkg::CHANNELS_DEFAULT   // 1 .. 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // poll input
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [tcd_pkg::REQ_DATA_W-1:0]  req_tdata,  // [11:0] raw_touch, [43:12] now_ms
   // result output
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [tcd_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // [11:0] touch_events,
                                                             // [23:12] release_events,
                                                             // [35:24] stable_touched
   // settle time register
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [tcd_pkg::SETTLE_W-1:0]    csr_data
);
   import tcd_pkg::*;

   // config register
   logic [SETTLE_W-1:0] settle_ff;

   // input stage
   logic                s1_vld_ff;
   logic [RAW_W-1:0]    s1_raw_ff;
   logic [TIME_W-1:0]   s1_now_ff;

   // result stage
   logic                rsp_vld_ff, rsp_vld_in;
   logic [RAW_W-1:0]    touch_ff, rel_ff, stable_ff;

   logic                advance;
   logic                req_accept;

   logic [CHANNELS-1:0] lane_level;
   lane_out_type        lane_out [CHANNELS];
   logic [RAW_W-1:0]    touch_vec, rel_vec, stable_vec;

   // settle_ms is to be changed by the user only while idle; the block does not enforce this
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_RESET;
      end else if (csr_valid && csr_ready) begin
         settle_ff <= csr_data;
      end
   end

   // pipeline control: poll moves into the lanes when the result slot is free or being taken
   assign advance    = s1_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !s1_vld_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_tready) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_raw_ff <= req_tdata[RAW_W-1:0];
         s1_now_ff <= req_tdata[RAW_W +: TIME_W];
      end
   end

   // lanes; channels past the raw width read as untouched
   for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
      if (i < RAW_W) begin : g_in
         assign lane_level[i] = s1_raw_ff[i];
      end else begin : g_zero
         assign lane_level[i] = 1'b0;
      end

      tcd_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .step     (advance),
         .level    (lane_level[i]),
         .now      (s1_now_ff),
         .settle   (settle_ff),
         .lane_out (lane_out[i])
      );
   end

   // gather masks; bits with no lane stay clear
   for (genvar i = 0; i < RAW_W; i++) begin : g_mask
      if (i < CHANNELS) begin : g_have
         assign touch_vec[i]  = lane_out[i].touch_ev;
         assign rel_vec[i]    = lane_out[i].rel_ev;
         assign stable_vec[i] = lane_out[i].stable;
      end else begin : g_none
         assign touch_vec[i]  = 1'b0;
         assign rel_vec[i]    = 1'b0;
         assign stable_vec[i] = 1'b0;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         touch_ff  <= touch_vec;
         rel_ff    <= rel_vec;
         stable_ff <= stable_vec;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 3 * RAW_W){1'b0}}, stable_ff, rel_ff, touch_ff};

   // a held poll must not vanish from the input stage
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !advance) |=> s1_vld_ff)
      else $error("input stage dropped a poll");

   // a lane never reports touch and release on one poll
   a_ev_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> ((touch_ff & rel_ff) == '0))
      else $error("touch and release event on same lane");

   // a touch event leaves the lane touched
   a_touch_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> ((touch_ff & ~stable_ff) == '0))
      else $error("touch event without stable touch");

   // a release event leaves the lane idle
   a_rel_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> ((rel_ff & stable_ff) == '0))
      else $error("release event while still touched");

   // a result appears in the cycle after a poll leaves the input stage
   a_adv_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("result not loaded after advance");

endmodule

`default_nettype wire
